[src/pea_pkg.sv]
package pea_pkg;

  localparam int RING_DEPTH = 128;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int COORD_W    = 32;
  localparam int BTN_W      = 3;
  localparam int CNT_W      = 32;
  localparam int ENTRY_W    = 2 * COORD_W + BTN_W;

  localparam logic [COORD_W-1:0] LIMIT_RESET  = 32'd32767;
  localparam logic [COORD_W-1:0] CENTER_RESET = 32'd16383;

  // item kinds
  typedef enum logic [1:0] {
    ACT_EVENT = 2'd0,
    ACT_FLUSH = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // event classes
  localparam logic [15:0] EV_SYN = 16'd0;
  localparam logic [15:0] EV_KEY = 16'd1;
  localparam logic [15:0] EV_REL = 16'd2;
  localparam logic [15:0] EV_ABS = 16'd3;

  // event codes
  localparam logic [15:0] AXIS_X         = 16'd0;
  localparam logic [15:0] AXIS_Y         = 16'd1;
  localparam logic [15:0] SYNC_FRAME_END = 16'd0;
  localparam logic [15:0] KEY_LEFT       = 16'h0110;
  localparam logic [15:0] KEY_RIGHT      = 16'h0111;
  localparam logic [15:0] KEY_MIDDLE     = 16'h0112;

  // config register indexes
  localparam logic [0:0] REG_LIMIT_X = 1'b0;
  localparam logic [0:0] REG_LIMIT_Y = 1'b1;

  // ring access request for one item
  typedef struct packed {
    logic               we;
    logic [PTR_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [PTR_W-1:0]   raddr;
    logic               fwd;
  } ring_req_t;

  // pointer state and statistics after one item
  typedef struct packed {
    logic               report_valid;
    logic [COORD_W-1:0] now_x;
    logic [COORD_W-1:0] now_y;
    logic [BTN_W-1:0]   now_buttons;
    logic [CNT_W-1:0]   raw_count;
    logic [CNT_W-1:0]   queued_count;
    logic [CNT_W-1:0]   dropped_count;
    logic [CNT_W-1:0]   read_count;
  } item_status_t;

endpackage

[src/pea_ring_ram.sv]
module pea_ring_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 67
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pea_ctrl.sv]
module pea_ctrl
  import pea_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [1:0]         action,
  input  logic [15:0]        event_type,
  input  logic [15:0]        event_code,
  input  logic [31:0]        event_value,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output ring_req_t          req,
  output item_status_t       status
);

  logic [COORD_W-1:0] limit_x;
  logic [COORD_W-1:0] limit_y;
  logic [COORD_W-1:0] pos_x, pos_x_next;
  logic [COORD_W-1:0] pos_y, pos_y_next;
  logic [BTN_W-1:0]   buttons, buttons_next;
  logic               pending, pending_next;
  logic [PTR_W-1:0]   rptr, rptr_next, rptr_inc;
  logic [PTR_W-1:0]   wptr, wptr_next, wptr_inc;
  logic [CNT_W-1:0]   cnt_raw, cnt_queued, cnt_dropped, cnt_reads;
  logic [CNT_W-1:0]   cnt_raw_next, cnt_queued_next, cnt_dropped_next, cnt_reads_next;
  logic [BTN_W-1:0]   key_bit;
  logic               push_try, push_ok, do_read, rd_hit;
  logic [COORD_W-1:0] rel_x, rel_y;

  // saturating signed move
  function automatic logic [COORD_W-1:0] move_axis(
    input logic [COORD_W-1:0] pos,
    input logic [COORD_W-1:0] delta,
    input logic [COORD_W-1:0] limit
  );
    logic signed [COORD_W+1:0] sum;
    sum = $signed({2'b00, pos}) + $signed({{2{delta[COORD_W-1]}}, delta});
    if (sum[COORD_W+1]) begin
      return '0;
    end else if (sum[COORD_W:0] > {1'b0, limit}) begin
      return limit;
    end else begin
      return sum[COORD_W-1:0];
    end
  endfunction

  assign rel_x    = move_axis(pos_x, event_value, limit_x);
  assign rel_y    = move_axis(pos_y, event_value, limit_y);
  assign rptr_inc = (rptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
  assign wptr_inc = (wptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);

  always_comb begin
    case (event_code)
      KEY_LEFT:   key_bit = 3'b001;
      KEY_RIGHT:  key_bit = 3'b010;
      KEY_MIDDLE: key_bit = 3'b100;
      default:    key_bit = 3'b000;
    endcase
  end

  always_comb begin
    pos_x_next   = pos_x;
    pos_y_next   = pos_y;
    buttons_next = buttons;
    pending_next = pending;
    push_try     = 1'b0;
    do_read      = 1'b0;
    cnt_raw_next = cnt_raw;
    cnt_reads_next = cnt_reads;
    case (action_t'(action))
      ACT_EVENT: begin
        cnt_raw_next = cnt_raw + CNT_W'(1);
        case (event_type)
          EV_ABS: begin
            if (event_code == AXIS_X) begin
              pos_x_next   = event_value;
              pending_next = 1'b1;
            end else if (event_code == AXIS_Y) begin
              pos_y_next   = event_value;
              pending_next = 1'b1;
            end
          end
          EV_REL: begin
            if (event_code == AXIS_X) begin
              pos_x_next   = rel_x;
              pending_next = 1'b1;
            end else if (event_code == AXIS_Y) begin
              pos_y_next   = rel_y;
              pending_next = 1'b1;
            end
          end
          EV_KEY: begin
            if (key_bit != '0) begin
              buttons_next = (event_value != '0) ? (buttons | key_bit) : (buttons & ~key_bit);
              pending_next = 1'b1;
            end
          end
          EV_SYN: begin
            push_try = pending && (event_code == SYNC_FRAME_END);
          end
          default: ;
        endcase
      end
      ACT_FLUSH: begin
        push_try = pending;
      end
      ACT_READ: begin
        push_try       = pending;
        do_read        = 1'b1;
        cnt_reads_next = cnt_reads + CNT_W'(1);
      end
      default: ;
    endcase
    if (push_try) begin
      pending_next = 1'b0;
    end
  end

  // one slot stays free
  assign push_ok          = push_try && (wptr_inc != rptr);
  assign wptr_next        = push_ok ? wptr_inc : wptr;
  assign rd_hit           = do_read && (rptr != wptr_next);
  assign rptr_next        = rd_hit ? rptr_inc : rptr;
  assign cnt_queued_next  = push_ok ? cnt_queued + CNT_W'(1) : cnt_queued;
  assign cnt_dropped_next = (push_try && !push_ok) ? cnt_dropped + CNT_W'(1) : cnt_dropped;

  always_comb begin
    req.we    = take && push_ok;
    req.waddr = wptr;
    req.wdata = {buttons, pos_y, pos_x};
    req.re    = take && rd_hit;
    req.raddr = rptr;
    // read slot is the one written by this same item
    req.fwd   = push_ok && (rptr == wptr);
  end

  always_comb begin
    status.report_valid  = rd_hit;
    status.now_x         = pos_x_next;
    status.now_y         = pos_y_next;
    status.now_buttons   = buttons_next;
    status.raw_count     = cnt_raw_next;
    status.queued_count  = cnt_queued_next;
    status.dropped_count = cnt_dropped_next;
    status.read_count    = cnt_reads_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_x <= LIMIT_RESET;
      limit_y <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT_X: limit_x <= cfg_data;
        REG_LIMIT_Y: limit_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= CENTER_RESET;
      pos_y       <= CENTER_RESET;
      buttons     <= '0;
      pending     <= 1'b1;
      rptr        <= '0;
      wptr        <= '0;
      cnt_raw     <= '0;
      cnt_queued  <= '0;
      cnt_dropped <= '0;
      cnt_reads   <= '0;
    end else if (take) begin
      pos_x       <= pos_x_next;
      pos_y       <= pos_y_next;
      buttons     <= buttons_next;
      pending     <= pending_next;
      rptr        <= rptr_next;
      wptr        <= wptr_next;
      cnt_raw     <= cnt_raw_next;
      cnt_queued  <= cnt_queued_next;
      cnt_dropped <= cnt_dropped_next;
      cnt_reads   <= cnt_reads_next;
    end
  end

`ifndef SYNTH
  a_fwd_needs_both: assert property (@(posedge clk) disable iff (rst)
    (req.fwd && req.re) |-> req.we)
    else $error("forward without a ring write");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (take && (action == ACT_FLUSH)) |=> !pending)
    else $error("pending change left after flush");

  a_push_counted: assert property (@(posedge clk) disable iff (rst)
    (take && push_try) |=>
      ((cnt_queued != $past(cnt_queued)) || (cnt_dropped != $past(cnt_dropped))))
    else $error("report push neither queued nor dropped");

  // a push that is not read back by the same item leaves the ring non-empty
  a_write_leaves_gap: assert property (@(posedge clk) disable iff (rst)
    (take && push_ok && !rd_hit) |=> (wptr != rptr))
    else $error("ring became empty after a push");
`endif

endmodule

[src/pointer_event_accumulator_core.sv]
// channel   dir  tdata (low bit up)                                 tuser
// --------  ---  -------------------------------------------------  -------------------
// s_axis    in   event_type[15:0], event_code[15:0], event_value    action[1:0]
// m_axis    out  report_buttons, report_x, report_y, now_x, now_y,  report_valid
//                now_buttons, raw/queued/dropped/read counts, pad
// cfg       in   cfg_we, cfg_index (0 limit_x, 1 limit_y), cfg_data
//
// one transaction per cycle in and one result per cycle out while m_tready stays high;
// each transaction passes the ring read port, then the output register
// rst is synchronous: position 16383/16383, buttons clear, change pending,
// ring empty, counters zero, limits 32767; ring storage is not cleared
// a stalled output holds its register; the input keeps flowing until both
// the output register and the ring-read stage are occupied
module pointer_event_accumulator_core
  import pea_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // event_type[15:0], event_code[31:16], event_value[63:32]
  input  logic [63:0]  s_tdata,
  // action[1:0]
  input  logic [1:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // report_buttons[2:0], report_x[34:3], report_y[66:35], now_x[98:67],
  // now_y[130:99], now_buttons[133:131], raw_count[165:134],
  // queued_count[197:166], dropped_count[229:198], read_count[261:230], zero pad
  output logic [263:0] m_tdata,
  // report_valid[0]
  output logic [0:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic               take;
  logic               s1_advance;
  ring_req_t          req;
  item_status_t       status;
  logic [ENTRY_W-1:0] ram_rdata;

  // stage 1: ring read in flight
  logic               s1_valid;
  item_status_t       s1_status;
  logic               s1_fwd;
  logic [ENTRY_W-1:0] s1_fwd_data;

  logic [ENTRY_W-1:0] s1_entry;
  logic [BTN_W-1:0]   rep_buttons;
  logic [COORD_W-1:0] rep_x;
  logic [COORD_W-1:0] rep_y;

  assign take       = s_tvalid && s_tready;
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;

  pea_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .action      (s_tuser),
    .event_type  (s_tdata[15:0]),
    .event_code  (s_tdata[31:16]),
    .event_value (s_tdata[63:32]),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req),
    .status      (status)
  );

  pea_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ring (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of stage 1, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      s1_status   <= status;
      s1_fwd      <= req.fwd;
      s1_fwd_data <= req.wdata;
    end
  end

  // same-item push then read: ram returns the old slot, take the pushed data
  assign s1_entry    = s1_fwd ? s1_fwd_data : ram_rdata;
  assign rep_x       = s1_status.report_valid ? s1_entry[COORD_W-1:0] : '0;
  assign rep_y       = s1_status.report_valid ? s1_entry[2*COORD_W-1:COORD_W] : '0;
  assign rep_buttons = s1_status.report_valid ? s1_entry[ENTRY_W-1:2*COORD_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tuser <= s1_status.report_valid;
      m_tdata <= {2'b00,
                  s1_status.read_count,
                  s1_status.dropped_count,
                  s1_status.queued_count,
                  s1_status.raw_count,
                  s1_status.now_buttons,
                  s1_status.now_y,
                  s1_status.now_x,
                  rep_y,
                  rep_x,
                  rep_buttons};
    end
  end

endmodule

[test/testbench.sv]
module testbench;
  import pea_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  // one result word as the block reports it
  typedef struct packed {
    logic               valid;
    logic [BTN_W-1:0]   rep_btn;
    logic [COORD_W-1:0] rep_x;
    logic [COORD_W-1:0] rep_y;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [BTN_W-1:0]   cur_btn;
    logic [CNT_W-1:0]   n_raw;
    logic [CNT_W-1:0]   n_queued;
    logic [CNT_W-1:0]   n_dropped;
    logic [CNT_W-1:0]   n_reads;
  } pointer_report_t;

  // tracks pointer state, the report ring and the counters, and holds the
  // reports still owed by the block
  class pointer_scoreboard;
    logic [COORD_W-1:0] lim_x, lim_y;
    logic [COORD_W-1:0] pos_x, pos_y;
    logic [BTN_W-1:0]   btns;
    bit                 dirty;
    logic [COORD_W-1:0] slot_x[RING_DEPTH];
    logic [COORD_W-1:0] slot_y[RING_DEPTH];
    logic [BTN_W-1:0]   slot_btn[RING_DEPTH];
    int                 rd_ptr, wr_ptr;
    logic [CNT_W-1:0]   raw_n, queued_n, dropped_n, reads_n;
    pointer_report_t    owed_q[$];
    int                 errors;

    function new();
      lim_x = LIMIT_RESET;
      lim_y = LIMIT_RESET;
      pos_x = CENTER_RESET;
      pos_y = CENTER_RESET;
      btns = '0;
      dirty = 1'b1;
      rd_ptr = 0;
      wr_ptr = 0;
      raw_n = '0;
      queued_n = '0;
      dropped_n = '0;
      reads_n = '0;
      errors = 0;
    endfunction

    function void set_limit(logic [0:0] idx, logic [31:0] data);
      if (idx == REG_LIMIT_X) lim_x = data;
      else lim_y = data;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    // exact sum, saturating at zero and at the limit
    function logic [COORD_W-1:0] moved(logic [COORD_W-1:0] pos, logic [31:0] delta,
                                       logic [COORD_W-1:0] lim);
      logic signed [33:0] total;
      total = $signed({2'b00, pos}) + $signed({{2{delta[31]}}, delta});
      if (total < 0) return '0;
      if (total > $signed({2'b00, lim})) return lim;
      return total[31:0];
    endfunction

    function void snapshot();
      int nxt;
      if (!dirty) return;
      dirty = 1'b0;
      nxt = (wr_ptr + 1) % RING_DEPTH;
      if (nxt != rd_ptr) begin
        slot_x[wr_ptr] = pos_x;
        slot_y[wr_ptr] = pos_y;
        slot_btn[wr_ptr] = btns;
        wr_ptr = nxt;
        queued_n++;
      end else begin
        dropped_n++;
      end
    endfunction

    function void take_raw(logic [15:0] ev_type, logic [15:0] ev_code,
                           logic [31:0] ev_value);
      logic [BTN_W-1:0] mask;
      raw_n++;
      case (ev_type)
        EV_ABS: begin
          if (ev_code == AXIS_X) begin
            pos_x = ev_value;
            dirty = 1'b1;
          end else if (ev_code == AXIS_Y) begin
            pos_y = ev_value;
            dirty = 1'b1;
          end
        end
        EV_REL: begin
          if (ev_code == AXIS_X) begin
            pos_x = moved(pos_x, ev_value, lim_x);
            dirty = 1'b1;
          end else if (ev_code == AXIS_Y) begin
            pos_y = moved(pos_y, ev_value, lim_y);
            dirty = 1'b1;
          end
        end
        EV_KEY: begin
          mask = (ev_code == KEY_LEFT)   ? 3'b001 :
                 (ev_code == KEY_RIGHT)  ? 3'b010 :
                 (ev_code == KEY_MIDDLE) ? 3'b100 : 3'b000;
          if (mask != 3'b000) begin
            if (ev_value != 0) btns = btns | mask;
            else btns = btns & ~mask;
            dirty = 1'b1;
          end
        end
        EV_SYN: begin
          if (ev_code == SYNC_FRAME_END) snapshot();
        end
        default: ;
      endcase
    endfunction

    function void note_item(action_t act, logic [15:0] ev_type, logic [15:0] ev_code,
                            logic [31:0] ev_value);
      pointer_report_t want;
      want = '0;
      case (act)
        ACT_EVENT: take_raw(ev_type, ev_code, ev_value);
        ACT_FLUSH: snapshot();
        ACT_READ: begin
          reads_n++;
          snapshot();
          if (rd_ptr != wr_ptr) begin
            want.valid = 1'b1;
            want.rep_x = slot_x[rd_ptr];
            want.rep_y = slot_y[rd_ptr];
            want.rep_btn = slot_btn[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          end
        end
        default: ;
      endcase
      want.cur_x = pos_x;
      want.cur_y = pos_y;
      want.cur_btn = btns;
      want.n_raw = raw_n;
      want.n_queued = queued_n;
      want.n_dropped = dropped_n;
      want.n_reads = reads_n;
      owed_q.push_back(want);
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [263:0] tdata, logic [0:0] tuser);
      pointer_report_t want;
      if (owed_q.size() == 0) begin
        $error("result with no transaction waiting for it");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      match("report_valid",   32'(want.valid),   32'(tuser[0]));
      match("report_buttons", 32'(want.rep_btn), 32'(tdata[2:0]));
      match("report_x",       want.rep_x,        tdata[34:3]);
      match("report_y",       want.rep_y,        tdata[66:35]);
      match("now_x",          want.cur_x,        tdata[98:67]);
      match("now_y",          want.cur_y,        tdata[130:99]);
      match("now_buttons",    32'(want.cur_btn), 32'(tdata[133:131]));
      match("raw_count",      want.n_raw,        tdata[165:134]);
      match("queued_count",   want.n_queued,     tdata[197:166]);
      match("dropped_count",  want.n_dropped,    tdata[229:198]);
      match("read_count",     want.n_reads,      tdata[261:230]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [63:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [263:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  pointer_scoreboard sb = new();

  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int items_sent = 0;
  int cycles = 0;

  pointer_event_accumulator_core dut (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // both monitors sample at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_item(action_t'(s_tuser), s_tdata[15:0], s_tdata[31:16], s_tdata[63:32]);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // result side: random stall before each transaction while receiver_idles is set
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(action_t act, logic [15:0] ev_type, logic [15:0] ev_code,
                           logic [31:0] ev_value);
    int gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {ev_value, ev_code, ev_type};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_read();
    send_item(ACT_READ, 16'($urandom), 16'($urandom), $urandom);
  endtask

  // one write cycle, then cfg_we drops again before the task returns
  task automatic write_limit(logic [0:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_limit(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // registers are only touched once every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($urandom_range(0, 256)) - 32'd128;
    endcase
  endfunction

  function automatic logic [31:0] pick_coord(logic [31:0] lim);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return '0;
      2: return lim;
      default: return $urandom_range(lim, 0);
    endcase
  endfunction

  function automatic logic [31:0] pick_press();
    return ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
  endfunction

  task automatic send_noise(bit reads_on);
    action_t act;
    logic [15:0] ev_type, ev_code;
    act = reads_on ? action_t'($urandom_range(0, 3)) : ACT_EVENT;
    ev_type = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    case ($urandom_range(0, 3))
      0: ev_code = 16'($urandom_range(0, 2));
      1: ev_code = KEY_LEFT + 16'($urandom_range(0, 3));
      default: ev_code = 16'($urandom);
    endcase
    send_item(act, ev_type, ev_code, $urandom);
  endtask

  // a device batch: a few motion or button events, usually closed by a report
  task automatic send_frame(bit reads_on);
    int n;
    int pick;
    logic [15:0] axis;
    n = $urandom_range(1, 4);
    repeat (n) begin
      pick = $urandom_range(0, 9);
      axis = 16'($urandom_range(0, 1));
      if (pick < 4)
        send_item(ACT_EVENT, EV_REL, axis, pick_delta());
      else if (pick < 6)
        send_item(ACT_EVENT, EV_ABS, axis, pick_coord(axis == AXIS_X ? sb.lim_x : sb.lim_y));
      else if (pick < 9)
        send_item(ACT_EVENT, EV_KEY, KEY_LEFT + 16'($urandom_range(0, 2)), pick_press());
      else
        send_noise(reads_on);
    end
    pick = $urandom_range(0, 9);
    if (pick < 6 || (pick == 8 && !reads_on))
      send_item(ACT_EVENT, EV_SYN, SYNC_FRAME_END, $urandom);
    else if (pick == 7)
      send_item(ACT_FLUSH, 16'($urandom), 16'($urandom), $urandom);
    else if (pick == 8)
      send_read();
    // otherwise the batch stays open into the next one
    if (reads_on && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 2)) send_read();
  endtask

  task automatic run_directed();
    send_read();                                        // reset state is pending
    send_read();                                        // ring empty
    send_item(ACT_NONE, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_item(ACT_EVENT, EV_ABS, AXIS_X, 32'hffff_ffff); // above the limit
    send_item(ACT_EVENT, EV_REL, AXIS_X, 32'd1);         // clamps down to limit
    send_item(ACT_EVENT, EV_ABS, AXIS_Y, 32'd0);
    send_item(ACT_EVENT, EV_REL, AXIS_Y, 32'hffff_ffff); // below zero
    send_item(ACT_EVENT, EV_REL, AXIS_X, 32'h8000_0000);
    send_item(ACT_EVENT, EV_REL, AXIS_X, 32'h7fff_ffff);
    send_item(ACT_EVENT, EV_KEY, KEY_LEFT, 32'h8000_0000);
    send_item(ACT_EVENT, EV_KEY, KEY_RIGHT, 32'd1);
    send_item(ACT_EVENT, EV_KEY, KEY_MIDDLE, 32'hffff_ffff);
    send_item(ACT_EVENT, EV_KEY, KEY_LEFT, 32'd0);
    send_item(ACT_EVENT, EV_KEY, KEY_MIDDLE + 16'd1, 32'd1); // unknown key
    send_item(ACT_EVENT, 16'hffff, 16'hffff, 32'hffff_ffff); // unknown class
    send_item(ACT_EVENT, EV_REL, 16'd2, 32'd5);
    send_item(ACT_EVENT, EV_ABS, 16'hffff, 32'd5);
    send_item(ACT_EVENT, EV_SYN, 16'd1, 32'd0);              // sync, not a report
    send_item(ACT_EVENT, EV_SYN, SYNC_FRAME_END, 32'd0);
    send_item(ACT_FLUSH, 16'd0, 16'd0, 32'd0);               // nothing pending
    send_item(ACT_EVENT, EV_ABS, AXIS_X, 32'd100);
    send_item(ACT_FLUSH, 16'hffff, 16'hffff, 32'hffff_ffff);
    repeat (3) send_read();
  endtask

  initial begin
    logic [31:0] lim_a, lim_b;
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin lim_a = LIMIT_RESET; lim_b = LIMIT_RESET; end
        1: begin lim_a = '0; lim_b = '0; end
        2: begin lim_a = 32'hffff_ffff; lim_b = 32'hffff_ffff; end
        3: begin lim_a = $urandom_range(1, 1000); lim_b = $urandom_range(1, 1000); end
        4: begin lim_a = $urandom; lim_b = '0; end
        5: begin lim_a = 32'd1; lim_b = 32'hffff_ffff; end
        default: begin lim_a = $urandom; lim_b = $urandom; end
      endcase
      write_limit(REG_LIMIT_X, lim_a);
      write_limit(REG_LIMIT_Y, lim_b);
      sender_idles = (phase != 1 && phase != 4);
      receiver_idles = (phase != 3 && phase != 4);

      if (phase == 0) run_directed();
      if (phase == 2) begin
        // overfill the ring so pushes get dropped, then read it dry
        repeat (140) begin
          send_item(ACT_EVENT, EV_REL, 16'($urandom_range(0, 1)), pick_delta());
          send_item(ACT_EVENT, EV_SYN, SYNC_FRAME_END, $urandom);
        end
        repeat (130) send_read();
      end else begin
        target = items_sent + 110;
        while (items_sent < target) send_frame(1'b1);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
